// ===== hdl/fsa_pkg.sv =====
// Shared types and constants for the free-list slot allocator.
// Holds the field widths, result codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package fsa_pkg;

	localparam int SLOT_W      = 10;
	localparam int CNT_W       = 11;
	localparam int LIMIT_RESET = 1024;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_BAD_FREE  = 2'd2
	} status_t;

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_HOLD
	} fsm_state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;       // latch request, read link at list head
		logic exec;       // serve request, update pool state
		logic save;       // park the result while the output is occupied
		logic load_exec;  // load output from the result being computed
		logic load_held;  // load output from the parked result
	} fsa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;   // output register can take a result this cycle
	} fsa_stat_t;

endpackage

// ===== hdl/fsa_ctrl.sv =====
// Controller state machine for the slot allocator.
// Depends on fsa_pkg for the state enum and the command/status structs.
module fsa_ctrl import fsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output fsa_cmd_t  cmd,
	input  fsa_stat_t stat
);

	fsm_state_t state_q;
	fsm_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (in_valid) begin
					state_nxt = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				state_nxt = stat.out_free ? FSM_IDLE : FSM_HOLD;
			end
			FSM_HOLD: begin
				if (stat.out_free) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: state_nxt = FSM_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			FSM_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			FSM_EXEC: begin
				cmd.exec      = 1'b1;
				cmd.load_exec = stat.out_free;
				cmd.save      = !stat.out_free;
			end
			FSM_HOLD: begin
				cmd.load_held = stat.out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

endmodule

// ===== hdl/fsa_dp.sv =====
// Datapath for the slot allocator: link memory, list head, watermark,
// counters, limit register, result holding and output registers.
// Depends on fsa_pkg for widths, codes and the command/status structs.
module fsa_dp import fsa_pkg::*; #(
	parameter int NUM_SLOTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fsa_cmd_t           cmd,
	output fsa_stat_t          stat,
	input  logic               func,
	input  logic [SLOT_W-1:0]  slot_in,
	input  logic               cfg_we,
	input  logic [CNT_W-1:0]   cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SLOT_W-1:0]  slot_out,
	output logic [1:0]         status,
	output logic [CNT_W-1:0]   in_use_count
);

	// Only slot indices below 1024 ever reach the list, so the memory
	// never needs more entries than that.
	localparam int MEM_DEPTH = (NUM_SLOTS < (1 << SLOT_W)) ? NUM_SLOTS : (1 << SLOT_W);
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam logic [31:0] NUM32 = NUM_SLOTS;

	logic [SLOT_W-1:0] link_mem [MEM_DEPTH];

	logic [CNT_W-1:0]  limit_q;
	logic [SLOT_W-1:0] head_q;
	logic              nonempty_q;
	logic [CNT_W-1:0]  wm_q;
	logic [CNT_W-1:0]  used_q;

	logic              req_func_q;
	logic [SLOT_W-1:0] req_slot_q;
	logic [SLOT_W-1:0] link_rd_q;

	logic [SLOT_W-1:0] res_slot_q;
	logic [1:0]        res_status_q;
	logic [CNT_W-1:0]  res_count_q;

	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [1:0]        out_status_q;
	logic [CNT_W-1:0]  out_count_q;

	logic [CNT_W-1:0]  eff_lim;
	logic [CNT_W-1:0]  used_inc;
	logic              pool_full;
	logic              do_pop;
	logic              do_fresh;
	logic              do_push;
	logic [SLOT_W-1:0] r_slot;
	status_t           r_status;
	logic [CNT_W-1:0]  r_count;

	assign eff_lim   = (32'(limit_q) > NUM32) ? NUM32[CNT_W-1:0] : limit_q;
	assign used_inc  = used_q + CNT_W'(1);
	assign pool_full = 32'(used_q) >= NUM32;

	always_comb begin
		do_pop   = 1'b0;
		do_fresh = 1'b0;
		do_push  = 1'b0;
		r_slot   = '0;
		r_status = ST_OK;
		r_count  = used_q;
		if (req_func_q == FUNC_ALLOC) begin
			if (pool_full) begin
				r_status = ST_EXHAUSTED;
			end else if (nonempty_q) begin
				do_pop  = 1'b1;
				r_slot  = head_q;
				r_count = used_inc;
			end else if (wm_q < eff_lim) begin
				do_fresh = 1'b1;
				r_slot   = wm_q[SLOT_W-1:0];
				r_count  = used_inc;
			end else begin
				r_status = ST_EXHAUSTED;
			end
		end else begin
			if (used_q == '0 || CNT_W'(req_slot_q) >= wm_q) begin
				r_status = ST_BAD_FREE;
			end else begin
				do_push = 1'b1;
				r_count = used_q - CNT_W'(1);
			end
		end
	end

	// link memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.exec && do_push) begin
			link_mem[req_slot_q[AW-1:0]] <= head_q;
		end
		if (cmd.take) begin
			link_rd_q <= link_mem[head_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_func_q <= func;
			req_slot_q <= slot_in;
		end
		if (cmd.save) begin
			res_slot_q   <= r_slot;
			res_status_q <= r_status;
			res_count_q  <= r_count;
		end
		if (cmd.load_exec) begin
			out_slot_q   <= r_slot;
			out_status_q <= r_status;
			out_count_q  <= r_count;
		end else if (cmd.load_held) begin
			out_slot_q   <= res_slot_q;
			out_status_q <= res_status_q;
			out_count_q  <= res_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= CNT_W'(LIMIT_RESET);
			head_q     <= '0;
			nonempty_q <= 1'b0;
			wm_q       <= '0;
			used_q     <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.exec) begin
				used_q <= r_count;
				if (do_pop) begin
					head_q     <= link_rd_q;
					nonempty_q <= used_inc < wm_q;
				end
				if (do_fresh) begin
					wm_q <= wm_q + CNT_W'(1);
				end
				if (do_push) begin
					head_q     <= req_slot_q;
					nonempty_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_exec || cmd.load_held) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign slot_out     = out_slot_q;
	assign status       = out_status_q;
	assign in_use_count = out_count_q;

endmodule

// ===== hdl/free_list_slot_allocator.sv =====
// Top level of the free-list slot allocator.
// Instantiates fsa_ctrl and fsa_dp; depends on fsa_pkg.

// Pool of fixed-size slots named by index, handed out and taken back
// through a LIFO free list kept as a linked list in an on-chip link
// memory. An allocate (func 0) pops the head of the free list; with the
// list empty it grants the next never-used slot from a watermark, up to
// min(slot_limit, NUM_SLOTS), and reports exhausted beyond that. A free
// (func 1) pushes slot_in onto the list; freeing a slot at or above the
// watermark, or freeing with nothing in use, is reported and ignored.
// Double frees are not detected. Every item gives exactly one result
// carrying the granted slot (0 unless the allocate succeeded), a status
// code and the in-use count after the item. An item is accepted in IDLE
// and served in EXEC, which loads its result into the output register
// when that is free; no new item is taken before the block is back in
// IDLE. Serving has its own state as the registered link memory read
// fetches the list head's successor. While a result waits on out_stall
// the block still accepts and serves one further item, parking its result
// until the output register frees. The link memory needs no clearing
// after reset and slot_limit (reset 1024) may be written only while idle.
module free_list_slot_allocator import fsa_pkg::*; #(
	parameter int NUM_SLOTS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [SLOT_W-1:0] slot_in,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SLOT_W-1:0] slot_out,
	output logic [1:0]        status,
	output logic [CNT_W-1:0]  in_use_count,
	// slot_limit write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data
);

	fsa_cmd_t  cmd;
	fsa_stat_t stat;

	// the limit register takes a write in any cycle
	assign cfg_ready = 1'b1;

	fsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	fsa_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (func),
		.slot_in      (slot_in),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.slot_out     (slot_out),
		.status       (status),
		.in_use_count (in_use_count)
	);

endmodule

// ===== hdl/fsa_checker.sv =====
// Port-level checks for the free-list slot allocator, and the bind that
// attaches them to free_list_slot_allocator. Depends on fsa_pkg.
module fsa_checker import fsa_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [SLOT_W-1:0] slot_out,
	input logic [1:0]        status,
	input logic [CNT_W-1:0]  in_use_count
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(slot_out)
			&& $stable(status) && $stable(in_use_count))
		else $error("stalled result changed");

	// only defined result codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_EXHAUSTED
			|| status == ST_BAD_FREE)
		else $error("undefined status code");

	// a failed item grants nothing
	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> slot_out == '0)
		else $error("failed item carries a slot");

	// the block is busy in the cycle after it takes an item
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken back to back");

endmodule

bind free_list_slot_allocator fsa_checker u_fsa_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for free_list_slot_allocator.
// Drives a directed table and then random allocate and free items, and checks
// every result against a predictor of the pool kept here. Depends on fsa_pkg.
module tb_top import fsa_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_SLOTS  = 1024;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOW_ERRORS = 10;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  count_t;

	// one result item as the block reports it
	typedef struct packed {
		slot_t   slot;
		status_t stat;
		count_t  count;
	} grant_t;

	// a directed row; the result is typed in only where it is obvious
	typedef struct {
		func_t   op;
		slot_t   slot;
		bit      typed;
		slot_t   w_slot;
		status_t w_stat;
		count_t  w_count;
	} plan_row_t;

	// mix of requests within a random phase
	typedef enum {PACE_MIXED, PACE_FILL, PACE_DRAIN} pace_t;

	typedef struct {
		int    limit;  // below zero: pick a small limit at random
		int    items;
		pace_t pace;
	} phase_t;

	logic   clk      = 1'b0;
	logic   arst_n   = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	func_t  func     = FUNC_ALLOC;
	slot_t  slot_in  = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	slot_t  slot_out;
	logic [1:0] status;
	count_t in_use_count;
	logic   cfg_valid = 1'b0;
	logic   cfg_ready;
	count_t cfg_data  = '0;

	int cycle_cnt = 0;
	int err_cnt   = 0;

	// results still owed by the block, oldest first
	grant_t pending_grants[$];
	// slots the traffic generator believes it holds, used for well-formed frees
	slot_t  held_slots[$];

	// shadow of the pool
	slot_t  next_slot [POOL_SLOTS];
	slot_t  head_q    = '0;
	bit     list_live = 1'b0;
	count_t fresh_q   = '0;
	count_t used_q    = '0;
	count_t limit_q   = count_t'(LIMIT_RESET);

	// Directed rows, run at the reset limit of 1024. Error results and the
	// first grants after reset are typed in; the rest come from the predictor.
	localparam int N_PLAN = 20;
	plan_row_t plan [N_PLAN] = '{
		// free with nothing in use, at both ends of the slot range
		'{FUNC_FREE,  10'd0,    1'b1, 10'd0, ST_BAD_FREE, 11'd0},
		'{FUNC_FREE,  10'd1023, 1'b1, 10'd0, ST_BAD_FREE, 11'd0},
		// fresh grants; slot_in is ignored on allocate
		'{FUNC_ALLOC, 10'd1023, 1'b1, 10'd0, ST_OK,       11'd1},
		'{FUNC_ALLOC, 10'h2AA,  1'b1, 10'd1, ST_OK,       11'd2},
		'{FUNC_ALLOC, 10'h155,  1'b0, 10'd0, ST_OK,       11'd0},
		// free at and far above the watermark
		'{FUNC_FREE,  10'd3,    1'b1, 10'd0, ST_BAD_FREE, 11'd3},
		'{FUNC_FREE,  10'd1023, 1'b1, 10'd0, ST_BAD_FREE, 11'd3},
		// double free goes undetected and the slot is granted twice
		'{FUNC_FREE,  10'd1,    1'b0, 10'd0, ST_OK,       11'd0},
		'{FUNC_FREE,  10'd1,    1'b0, 10'd0, ST_OK,       11'd0},
		'{FUNC_ALLOC, 10'd0,    1'b0, 10'd0, ST_OK,       11'd0},
		'{FUNC_ALLOC, 10'd0,    1'b0, 10'd0, ST_OK,       11'd0},
		// list drained, back to the watermark
		'{FUNC_ALLOC, 10'd0,    1'b0, 10'd0, ST_OK,       11'd0},
		// LIFO order over three pushes
		'{FUNC_FREE,  10'd0,    1'b0, 10'd0, ST_OK,       11'd0},
		'{FUNC_FREE,  10'd2,    1'b0, 10'd0, ST_OK,       11'd0},
		'{FUNC_FREE,  10'd3,    1'b0, 10'd0, ST_OK,       11'd0},
		'{FUNC_ALLOC, 10'd7,    1'b0, 10'd0, ST_OK,       11'd0},
		'{FUNC_ALLOC, 10'd0,    1'b0, 10'd0, ST_OK,       11'd0},
		'{FUNC_ALLOC, 10'd0,    1'b0, 10'd0, ST_OK,       11'd0},
		'{FUNC_ALLOC, 10'd0,    1'b0, 10'd0, ST_OK,       11'd0},
		'{FUNC_FREE,  10'd1,    1'b0, 10'd0, ST_OK,       11'd0}
	};

	// Random phases, each opened by a limit write with the block idle.
	// Zero and one exercise the zero and lowered limits, 2047 sits above the
	// pool size and the fill phase runs the pool dry.
	localparam int N_PHASES = 6;
	phase_t phases [N_PHASES] = '{
		'{0,    40,   PACE_MIXED},
		'{1,    40,   PACE_MIXED},
		'{2047, 1150, PACE_FILL},
		'{1024, 180,  PACE_DRAIN},
		'{-1,   120,  PACE_MIXED},
		'{5,    100,  PACE_MIXED}
	};

	free_list_slot_allocator #(
		.NUM_SLOTS(POOL_SLOTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.slot_in      (slot_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.slot_out     (slot_out),
		.status       (status),
		.in_use_count (in_use_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// a stretch in mid-run where neither side idles
	function automatic bit quiet_spell();
		return cycle_cnt >= 1800 && cycle_cnt < 2800;
	endfunction

	function automatic void flag_error(string msg);
		err_cnt++;
		if (err_cnt <= SHOW_ERRORS) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endfunction

	// Serve one request on the shadow pool and return the result it gives.
	function automatic grant_t serve_request(func_t op, slot_t slot);
		grant_t g;
		count_t cap;
		g.slot  = '0;
		g.stat  = ST_OK;
		cap     = (limit_q > POOL_SLOTS) ? count_t'(POOL_SLOTS) : limit_q;
		if (op == FUNC_ALLOC) begin
			if (used_q >= POOL_SLOTS) begin
				g.stat = ST_EXHAUSTED;
			end else if (list_live) begin
				// pop; the list length is the watermark less the slots in use
				g.slot    = head_q;
				head_q    = next_slot[head_q];
				used_q    = used_q + 1'b1;
				list_live = used_q < fresh_q;
			end else if (fresh_q < cap) begin
				g.slot  = fresh_q[SLOT_W-1:0];
				fresh_q = fresh_q + 1'b1;
				used_q  = used_q + 1'b1;
			end else begin
				g.stat = ST_EXHAUSTED;
			end
		end else begin
			if (used_q == 0 || slot >= fresh_q) begin
				g.stat = ST_BAD_FREE;
			end else begin
				// push onto the head; a double free is pushed like any other
				next_slot[slot] = head_q;
				head_q          = slot;
				list_live       = 1'b1;
				used_q          = used_q - 1'b1;
			end
		end
		g.count = used_q;
		return g;
	endfunction

	// Keep the generator's view of held slots in step with the grants.
	function automatic void track_held(func_t op, grant_t g);
		if (g.stat != ST_OK) begin
			return;
		end
		if (op == FUNC_ALLOC) begin
			held_slots.push_back(g.slot);
		end else begin
			for (int i = 0; i < held_slots.size(); i++) begin
				if (held_slots[i] == g.slot) begin
					held_slots.delete(i);
					break;
				end
			end
		end
	endfunction

	// Hold the item on the request port until it is taken, predict its
	// result and queue either that or the typed-in one.
	task automatic send_request(func_t op, slot_t slot, bit typed, grant_t typed_g);
		grant_t g;
		in_valid <= 1'b1;
		func     <= op;
		slot_in  <= slot;
		do @(posedge clk); while (in_stall);
		g = serve_request(op, slot);
		// frees: the generator only needs the slot, which the grant leaves at zero
		if (op == FUNC_FREE && g.stat == ST_OK) begin
			track_held(op, '{slot: slot, stat: ST_OK, count: g.count});
		end else begin
			track_held(op, g);
		end
		pending_grants.push_back(typed ? typed_g : g);
		// idle the request port now and then
		if (!quiet_spell() && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	// Drop valid and wait for every owed result, within a bound.
	task automatic drain_results(int bound);
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_grants.size() != 0 && waited < bound) begin
			@(posedge clk);
			waited++;
		end
	endtask

	task automatic write_limit(count_t value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_q = value;
	endtask

	// Pick the next random request; mostly well-formed, with some noise.
	task automatic pick_request(pace_t pace, output func_t op, output slot_t slot);
		int alloc_pct;
		int roll;
		alloc_pct = (pace == PACE_FILL) ? 99 : (pace == PACE_DRAIN) ? 30 : 50;
		roll      = $urandom_range(9);
		op        = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
		// slot_in carries random bits on allocate too
		slot      = slot_t'($urandom);
		if (op == FUNC_FREE) begin
			if (roll < 7 && held_slots.size() > 0) begin
				slot = held_slots[$urandom_range(held_slots.size() - 1)];
			end else if (roll < 9 && fresh_q > 0) begin
				// any slot below the watermark, double frees included
				slot = slot_t'($urandom_range(int'(fresh_q) - 1));
			end
		end
	endtask

	// Result port: take results, compare against the oldest expectation,
	// stall at random.
	always @(posedge clk) begin
		grant_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_grants.size() == 0) begin
				flag_error($sformatf("result with none owed: slot %0d status %0d count %0d",
					slot_out, status, in_use_count));
			end else begin
				want = pending_grants.pop_front();
				if (slot_out !== want.slot) begin
					flag_error($sformatf("slot_out: expected %0d, got %0d", want.slot,
						slot_out));
				end
				if (status !== want.stat) begin
					flag_error($sformatf("status: expected %0d, got %0d", want.stat,
						status));
				end
				if (in_use_count !== want.count) begin
					flag_error($sformatf("in_use_count: expected %0d, got %0d",
						want.count, in_use_count));
				end
			end
		end
		out_stall <= !quiet_spell() && ($urandom_range(99) < 6);
	end

	// Watchdog: end the run if it goes on far past any correct length.
	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		func_t  op;
		slot_t  slot;
		grant_t typed_g;
		int     lim;

		// hold reset, then release it at a clock edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset limit
		for (int i = 0; i < N_PLAN; i++) begin
			typed_g = '{slot: plan[i].w_slot, stat: plan[i].w_stat,
				count: plan[i].w_count};
			send_request(plan[i].op, plan[i].slot, plan[i].typed, typed_g);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			// let the block go fully idle before touching the limit
			drain_results(1000);
			repeat (4) @(posedge clk);
			lim = (phases[p].limit < 0) ? $urandom_range(64, 2) : phases[p].limit;
			write_limit(count_t'(lim));
			for (int n = 0; n < phases[p].items; n++) begin
				pick_request(phases[p].pace, op, slot);
				send_request(op, slot, 1'b0, typed_g);
			end
		end

		// wait out the last results, then wait on for stragglers
		drain_results(2000);
		repeat (8) @(posedge clk);
		if (pending_grants.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", pending_grants.size()));
		end

		if (err_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== free_list_slot_allocator.f =====
hdl/fsa_pkg.sv
hdl/fsa_ctrl.sv
hdl/fsa_dp.sv
hdl/free_list_slot_allocator.sv
hdl/fsa_checker.sv
tb/sv/tb_top.sv
